// ----- rtl/spcp_pkg.sv -----
// spcp_pkg: shared constants and payload types for the segment pair closest points unit
// no dependencies; imported by every module of the block
package spcp_pkg;

    localparam int MAX_POINTS  = 256;
    localparam int ADDR_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int FRAC_W      = 16;
    localparam int DIV_STEPS   = FRAC_W;
    localparam logic [FRAC_W:0] ONE_Q16 = {1'b1, {FRAC_W{1'b0}}};

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef logic signed [23:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] point_index;
        coord_t     coord_x;
        coord_t     coord_y;
        coord_t     coord_z;
        logic [7:0] first_seg_start;
        logic [7:0] first_seg_end;
        logic [7:0] second_seg_start;
        logic [7:0] second_seg_end;
    } item_t;

    typedef struct packed {
        coord_t      near_first_x;
        coord_t      near_first_y;
        coord_t      near_first_z;
        coord_t      near_second_x;
        coord_t      near_second_y;
        coord_t      near_second_z;
        logic [16:0] param_first;
        logic [16:0] param_second;
    } result_t;

    typedef struct packed {
        point_t p1;
        point_t p2;
        point_t p3;
        point_t p4;
    } quad_t;

    typedef struct packed {
        logic             nonempty;
        logic [CNT_W-1:0] count;
    } queue_status_t;

endpackage

// ----- rtl/spcp_front.sv -----
// spcp_front: input transfer, point store (two copies for four reads per cycle), query fetch
// depends on spcp_pkg; feeds spcp_queue
module spcp_front
    import spcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  item_t         item,
    input  queue_status_t qstat,
    output logic          push,
    output quad_t         quad
);

    point_t mem_a [MAX_POINTS];
    point_t mem_b [MAX_POINTS];

    point_t rd1_reg, rd2_reg, rd3_reg, rd4_reg;
    logic   ok1_reg, ok2_reg, ok3_reg, ok4_reg;
    logic   f1_valid_reg;
    logic   accept;
    logic   load_en;
    point_t wr_point;

    function automatic logic in_range(logic [7:0] idx);
        return 32'(idx) < MAX_POINTS;
    endfunction

    assign item_stall = ({1'b0, qstat.count} + (CNT_W+1)'(f1_valid_reg))
                        >= (CNT_W+1)'(QUEUE_DEPTH);
    assign accept   = item_valid && !item_stall;
    assign load_en  = accept && (item.operation == OP_LOAD) && in_range(item.point_index);
    assign wr_point = '{x: item.coord_x, y: item.coord_y, z: item.coord_z};

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            mem_a[ADDR_W'(item.point_index)] <= wr_point;
        end
        rd1_reg <= mem_a[ADDR_W'(item.first_seg_start)];
        rd2_reg <= mem_a[ADDR_W'(item.first_seg_end)];
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            mem_b[ADDR_W'(item.point_index)] <= wr_point;
        end
        rd3_reg <= mem_b[ADDR_W'(item.second_seg_start)];
        rd4_reg <= mem_b[ADDR_W'(item.second_seg_end)];
    end

    always_ff @(posedge clk)
    begin
        ok1_reg <= in_range(item.first_seg_start);
        ok2_reg <= in_range(item.first_seg_end);
        ok3_reg <= in_range(item.second_seg_start);
        ok4_reg <= in_range(item.second_seg_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept && (item.operation == OP_QUERY);
        end
    end

    // out of range indices read as the origin
    assign push    = f1_valid_reg;
    assign quad.p1 = ok1_reg ? rd1_reg : '0;
    assign quad.p2 = ok2_reg ? rd2_reg : '0;
    assign quad.p3 = ok3_reg ? rd3_reg : '0;
    assign quad.p4 = ok4_reg ? rd4_reg : '0;

endmodule

// ----- rtl/spcp_queue.sv -----
// spcp_queue: short fifo of fetched queries between front and back
// depends on spcp_pkg; space is reserved by spcp_front before it issues a read
module spcp_queue
    import spcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  quad_t         din,
    input  logic          pop,
    output queue_status_t stat,
    output quad_t         head
);

    quad_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    assign head          = slot_reg[rd_ptr_reg];
    assign stat.nonempty = (count_reg != '0);
    assign stat.count    = count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && count_reg == CNT_W'(QUEUE_DEPTH)) |-> pop)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

// ----- rtl/spcp_back.sv -----
// spcp_back: arithmetic pipeline, dot products, split wide products, restoring divide, lerp
// depends on spcp_pkg; takes queries from spcp_queue and drives the result transfer
module spcp_back
    import spcp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_nonempty,
    input  quad_t   head,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    typedef logic signed [24:0]  diff_t;
    typedef logic signed [49:0]  prod_t;
    typedef logic signed [51:0]  dot_t;
    typedef logic signed [53:0]  part_t;
    typedef logic signed [103:0] wide_t;
    typedef logic signed [42:0]  lprod_t;

    typedef struct packed { diff_t x; diff_t y; diff_t z; } vec_t;
    typedef struct packed { prod_t x; prod_t y; prod_t z; } prod3_t;
    typedef struct packed { lprod_t x; lprod_t y; lprod_t z; } lvec_t;
    typedef struct packed { part_t hh; part_t hl; part_t lh; part_t ll; } parts_t;

    typedef struct packed {
        logic          done;
        logic [16:0]   fix;
        logic [103:0]  rem;
        logic [15:0]   quo;
    } div_t;

    typedef struct packed {
        point_t p1; point_t p3;
        vec_t a; vec_t b; vec_t c; vec_t d41; vec_t d32; vec_t d42;
    } st1_t;

    typedef struct packed {
        point_t p1; point_t p3; vec_t a; vec_t b;
        prod3_t aa; prod3_t bb; prod3_t ba; prod3_t ca; prod3_t bc;
        prod3_t cc; prod3_t e41; prod3_t e32; prod3_t e42;
    } st2_t;

    typedef struct packed {
        point_t p1; point_t p3; vec_t a; vec_t b;
        dot_t r21; dot_t r22; dot_t d4321; dot_t d3121; dot_t d4331;
        dot_t q13; dot_t q14; dot_t q23; dot_t q24;
    } st3_t;

    typedef struct packed {
        point_t p1; point_t p3; vec_t a; vec_t b;
        logic col_s; logic col_t;
        parts_t m0; parts_t m1; parts_t m2; parts_t m3; parts_t m4; parts_t m5;
    } st4_t;

    typedef struct packed {
        point_t p1; point_t p3; vec_t a; vec_t b;
        logic col_s; logic col_t;
        wide_t w0; wide_t w1; wide_t w2; wide_t w3; wide_t w4; wide_t w5;
    } st5_t;

    typedef struct packed {
        point_t p1; point_t p3; vec_t a; vec_t b;
        logic col_s; logic col_t;
        wide_t den; wide_t ns; wide_t nt;
    } st6_t;

    typedef struct packed {
        point_t p1; point_t p3; vec_t a; vec_t b;
        logic [103:0] den;
        div_t ds; div_t dt;
    } dv_t;

    typedef struct packed {
        point_t p1; point_t p3;
        lvec_t ms; lvec_t mt;
        logic [16:0] s; logic [16:0] t;
    } stl_t;

    function automatic vec_t vsub(point_t u, point_t w);
        vec_t r;
        r.x = diff_t'(u.x) - diff_t'(w.x);
        r.y = diff_t'(u.y) - diff_t'(w.y);
        r.z = diff_t'(u.z) - diff_t'(w.z);
        return r;
    endfunction

    function automatic prod3_t vmul(vec_t u, vec_t w);
        prod3_t r;
        r.x = u.x * w.x;
        r.y = u.y * w.y;
        r.z = u.z * w.z;
        return r;
    endfunction

    function automatic dot_t vsum(prod3_t p);
        return dot_t'(p.x) + dot_t'(p.y) + dot_t'(p.z);
    endfunction

    function automatic parts_t mul_parts(dot_t x, dot_t y);
        parts_t r;
        logic signed [26:0] xh, xl, yh, yl;
        xh = {x[51], x[51:26]};
        xl = {1'b0, x[25:0]};
        yh = {y[51], y[51:26]};
        yl = {1'b0, y[25:0]};
        r.hh = xh * yh;
        r.hl = xh * yl;
        r.lh = xl * yh;
        r.ll = xl * yl;
        return r;
    endfunction

    function automatic wide_t mul_join(parts_t p);
        wide_t hi, mid, lo;
        hi  = wide_t'(p.hh) <<< 52;
        mid = (wide_t'(p.hl) + wide_t'(p.lh)) <<< 26;
        lo  = wide_t'(p.ll);
        return hi + mid + lo;
    endfunction

    function automatic div_t div_init(wide_t num, wide_t den, logic col);
        div_t r;
        r.rem  = num;
        r.quo  = '0;
        r.done = 1'b1;
        r.fix  = '0;
        if (den == '0)
        begin
            r.fix = col ? ONE_Q16 : '0;
        end
        else if (num < 0)
        begin
            r.fix = '0;
        end
        else if (num >= den)
        begin
            r.fix = ONE_Q16;
        end
        else
        begin
            r.done = 1'b0;
        end
        return r;
    endfunction

    function automatic div_t div_step(div_t d, logic [103:0] den);
        div_t r;
        logic [103:0] r2;
        r  = d;
        r2 = {d.rem[102:0], 1'b0};
        if (!d.done)
        begin
            if (r2 >= den)
            begin
                r.rem = r2 - den;
                r.quo = {d.quo[14:0], 1'b1};
            end
            else
            begin
                r.rem = r2;
                r.quo = {d.quo[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic dv_t dv_advance(dv_t d);
        dv_t r;
        r    = d;
        r.ds = div_step(d.ds, d.den);
        r.dt = div_step(d.dt, d.den);
        return r;
    endfunction

    function automatic logic [16:0] div_val(div_t d);
        return d.done ? d.fix : {1'b0, d.quo};
    endfunction

    function automatic lvec_t lmul(logic [16:0] p, vec_t v);
        lvec_t r;
        logic signed [17:0] ps;
        ps  = {1'b0, p};
        r.x = ps * v.x;
        r.y = ps * v.y;
        r.z = ps * v.z;
        return r;
    endfunction

    function automatic coord_t lerp_out(coord_t p, lprod_t m);
        logic signed [43:0] v;
        logic signed [27:0] f;
        logic signed [28:0] sum;
        v   = 44'(m) + 44'sd32768;
        f   = 28'(v >>> 16);
        sum = 29'(p) + 29'(f);
        return sum[23:0];
    endfunction

    st1_t s1_reg;
    st2_t s2_reg;
    st3_t s3_reg;
    st4_t s4_reg;
    st5_t s5_reg;
    st6_t s6_reg;
    dv_t  dv_reg [0:DIV_STEPS];
    stl_t sl_reg;
    result_t result_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic [DIV_STEPS:0] dv_valid_reg;
    logic sl_valid_reg, out_valid_reg;
    logic adv;
    logic col_s_next, col_t_next;

    assign adv = !out_valid_reg || !result_stall;
    assign pop = adv && q_nonempty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            dv_valid_reg  <= '0;
            sl_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_nonempty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            dv_valid_reg  <= {dv_valid_reg[DIV_STEPS-1:0], s6_valid_reg};
            sl_valid_reg  <= dv_valid_reg[DIV_STEPS];
            out_valid_reg <= sl_valid_reg;
        end
    end

    // degenerate case: nearest endpoint pair, strict compares in order
    always_comb
    begin
        col_s_next = 1'b0;
        col_t_next = 1'b0;
        if (s3_reg.q14 < s3_reg.q13)
        begin
            col_t_next = 1'b1;
        end
        if (s3_reg.q23 < s3_reg.q14 && s3_reg.q23 < s3_reg.q13)
        begin
            col_s_next = 1'b1;
            col_t_next = 1'b0;
        end
        if (s3_reg.q24 < s3_reg.q23 && s3_reg.q24 < s3_reg.q14 && s3_reg.q24 < s3_reg.q13)
        begin
            col_s_next = 1'b1;
            col_t_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg.p1  <= head.p1;
            s1_reg.p3  <= head.p3;
            s1_reg.a   <= vsub(head.p2, head.p1);
            s1_reg.b   <= vsub(head.p4, head.p3);
            s1_reg.c   <= vsub(head.p3, head.p1);
            s1_reg.d41 <= vsub(head.p4, head.p1);
            s1_reg.d32 <= vsub(head.p3, head.p2);
            s1_reg.d42 <= vsub(head.p4, head.p2);

            s2_reg.p1  <= s1_reg.p1;
            s2_reg.p3  <= s1_reg.p3;
            s2_reg.a   <= s1_reg.a;
            s2_reg.b   <= s1_reg.b;
            s2_reg.aa  <= vmul(s1_reg.a, s1_reg.a);
            s2_reg.bb  <= vmul(s1_reg.b, s1_reg.b);
            s2_reg.ba  <= vmul(s1_reg.b, s1_reg.a);
            s2_reg.ca  <= vmul(s1_reg.c, s1_reg.a);
            s2_reg.bc  <= vmul(s1_reg.b, s1_reg.c);
            s2_reg.cc  <= vmul(s1_reg.c, s1_reg.c);
            s2_reg.e41 <= vmul(s1_reg.d41, s1_reg.d41);
            s2_reg.e32 <= vmul(s1_reg.d32, s1_reg.d32);
            s2_reg.e42 <= vmul(s1_reg.d42, s1_reg.d42);

            s3_reg.p1    <= s2_reg.p1;
            s3_reg.p3    <= s2_reg.p3;
            s3_reg.a     <= s2_reg.a;
            s3_reg.b     <= s2_reg.b;
            s3_reg.r21   <= vsum(s2_reg.aa);
            s3_reg.r22   <= vsum(s2_reg.bb);
            s3_reg.d4321 <= vsum(s2_reg.ba);
            s3_reg.d3121 <= vsum(s2_reg.ca);
            s3_reg.d4331 <= vsum(s2_reg.bc);
            s3_reg.q13   <= vsum(s2_reg.cc);
            s3_reg.q14   <= vsum(s2_reg.e41);
            s3_reg.q23   <= vsum(s2_reg.e32);
            s3_reg.q24   <= vsum(s2_reg.e42);

            s4_reg.p1    <= s3_reg.p1;
            s4_reg.p3    <= s3_reg.p3;
            s4_reg.a     <= s3_reg.a;
            s4_reg.b     <= s3_reg.b;
            s4_reg.col_s <= col_s_next;
            s4_reg.col_t <= col_t_next;
            s4_reg.m0    <= mul_parts(s3_reg.r21, s3_reg.r22);
            s4_reg.m1    <= mul_parts(s3_reg.d4321, s3_reg.d4321);
            s4_reg.m2    <= mul_parts(s3_reg.d3121, s3_reg.r22);
            s4_reg.m3    <= mul_parts(s3_reg.d4321, s3_reg.d4331);
            s4_reg.m4    <= mul_parts(s3_reg.d4321, s3_reg.d3121);
            s4_reg.m5    <= mul_parts(s3_reg.d4331, s3_reg.r21);

            s5_reg.p1    <= s4_reg.p1;
            s5_reg.p3    <= s4_reg.p3;
            s5_reg.a     <= s4_reg.a;
            s5_reg.b     <= s4_reg.b;
            s5_reg.col_s <= s4_reg.col_s;
            s5_reg.col_t <= s4_reg.col_t;
            s5_reg.w0    <= mul_join(s4_reg.m0);
            s5_reg.w1    <= mul_join(s4_reg.m1);
            s5_reg.w2    <= mul_join(s4_reg.m2);
            s5_reg.w3    <= mul_join(s4_reg.m3);
            s5_reg.w4    <= mul_join(s4_reg.m4);
            s5_reg.w5    <= mul_join(s4_reg.m5);

            s6_reg.p1    <= s5_reg.p1;
            s6_reg.p3    <= s5_reg.p3;
            s6_reg.a     <= s5_reg.a;
            s6_reg.b     <= s5_reg.b;
            s6_reg.col_s <= s5_reg.col_s;
            s6_reg.col_t <= s5_reg.col_t;
            s6_reg.den   <= s5_reg.w0 - s5_reg.w1;
            s6_reg.ns    <= s5_reg.w2 - s5_reg.w3;
            s6_reg.nt    <= s5_reg.w4 - s5_reg.w5;

            dv_reg[0].p1  <= s6_reg.p1;
            dv_reg[0].p3  <= s6_reg.p3;
            dv_reg[0].a   <= s6_reg.a;
            dv_reg[0].b   <= s6_reg.b;
            dv_reg[0].den <= s6_reg.den;
            dv_reg[0].ds  <= div_init(s6_reg.ns, s6_reg.den, s6_reg.col_s);
            dv_reg[0].dt  <= div_init(s6_reg.nt, s6_reg.den, s6_reg.col_t);

            sl_reg.p1 <= dv_reg[DIV_STEPS].p1;
            sl_reg.p3 <= dv_reg[DIV_STEPS].p3;
            sl_reg.s  <= div_val(dv_reg[DIV_STEPS].ds);
            sl_reg.t  <= div_val(dv_reg[DIV_STEPS].dt);
            sl_reg.ms <= lmul(div_val(dv_reg[DIV_STEPS].ds), dv_reg[DIV_STEPS].a);
            sl_reg.mt <= lmul(div_val(dv_reg[DIV_STEPS].dt), dv_reg[DIV_STEPS].b);

            result_reg.near_first_x  <= lerp_out(sl_reg.p1.x, sl_reg.ms.x);
            result_reg.near_first_y  <= lerp_out(sl_reg.p1.y, sl_reg.ms.y);
            result_reg.near_first_z  <= lerp_out(sl_reg.p1.z, sl_reg.ms.z);
            result_reg.near_second_x <= lerp_out(sl_reg.p3.x, sl_reg.mt.x);
            result_reg.near_second_y <= lerp_out(sl_reg.p3.y, sl_reg.mt.y);
            result_reg.near_second_z <= lerp_out(sl_reg.p3.z, sl_reg.mt.z);
            result_reg.param_first   <= sl_reg.s;
            result_reg.param_second  <= sl_reg.t;
        end
    end

    // one quotient bit per stage
    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[i] <= dv_advance(dv_reg[i-1]);
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/segment_pair_closest_points_unit.sv -----
// closest points between two 3d segments taken from a 256 entry point store
// throughput: one item per cycle while item_stall is low; a query passes the front fetch, the
// queue, then the split 52x52 products and the 16 stage restoring divide of the back pipeline
// loads give no result and finish in the transfer cycle
// reset clears the control state only; store entries are undefined until loaded
module segment_pair_closest_points_unit
    import spcp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    queue_status_t qstat;
    logic          push;
    logic          pop;
    quad_t         quad;
    quad_t         head;

    spcp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .qstat      (qstat),
        .push       (push),
        .quad       (quad)
    );

    spcp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (quad),
        .pop   (pop),
        .stat  (qstat),
        .head  (head)
    );

    spcp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_nonempty   (qstat.nonempty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
